// ===== src/cvpc_pkg.sv =====
package cvpc_pkg;

    // default converter resolutions
    localparam int ADC_BITS_DEF = 12;
    localparam int DAC_BITS_DEF = 12;

    // dividend width covers a 16-bit code times a 24-bit numerator plus rounding
    localparam int DIV_W = 41;
    // divisor and remainder width (24-bit gain denominator)
    localparam int DEN_W = 24;
    // sideband carried along the divider: kind and channel
    localparam int SIDE_W = 2;

    // register indexes
    localparam logic [2:0] REG_ADC_CAL_A = 3'd0;
    localparam logic [2:0] REG_ADC_CAL_B = 3'd1;
    localparam logic [2:0] REG_DAC_CAL_A = 3'd2;
    localparam logic [2:0] REG_DAC_CAL_B = 3'd3;
    localparam logic [2:0] REG_RANGE     = 3'd4;

    localparam logic [63:0] CAL_RESET   = 64'h0000_0100_0001_0000;
    localparam logic [6:0]  RANGE_RESET = 7'd60;

    // conversion directions
    localparam logic KIND_ADC = 1'b0;
    localparam logic KIND_DAC = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SIDE_W-1:0] side;
    } t_ctl;

endpackage

// ===== src/calibrated_cv_pitch_converter_unit.sv =====
// Calibrated CV pitch converter. One item is taken in every cycle (busy is
// always low) and its result appears on o_result_value with o_valid high for
// a single cycle; two registered chains of 41 division cells, one quotient
// bit per cell, compute it. Results leave in item order and cannot be held
// off, so the receiver must take each one in the cycle it is shown. The user
// must write calibration only while no item is in flight; the block does not
// enforce this. The write channel is always ready.
module calibrated_cv_pitch_converter_unit
    import cvpc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int DAC_BITS = DAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic               i_channel,
    input  logic [15:0]        i_adc_code,
    input  logic signed [15:0] i_target_pitch,
    output logic               o_valid,
    output logic [15:0]        o_result_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam logic [15:0] AMAX = 16'((32'd1 << ADC_BITS) - 32'd1);
    localparam logic [15:0] DMAX = 16'((32'd1 << DAC_BITS) - 32'd1);

    logic [63:0] r_adc_cal_a, r_adc_cal_b, r_dac_cal_a, r_dac_cal_b;
    logic [6:0]  r_range;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_cal_a <= CAL_RESET;
            r_adc_cal_b <= CAL_RESET;
            r_dac_cal_a <= CAL_RESET;
            r_dac_cal_b <= CAL_RESET;
            r_range     <= RANGE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ADC_CAL_A: r_adc_cal_a <= i_cfg_data;
                REG_ADC_CAL_B: r_adc_cal_b <= i_cfg_data;
                REG_DAC_CAL_A: r_dac_cal_a <= i_cfg_data;
                REG_DAC_CAL_B: r_dac_cal_b <= i_cfg_data;
                REG_RANGE:     r_range     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [14:0] max_pitch;
    assign max_pitch = {r_range, 8'd0};

    // ---------------- stage 0: first dividend ----------------
    logic [63:0]        w0;
    logic signed [17:0] corr;
    logic [15:0]        x0;
    logic [23:0]        den0;
    logic [39:0]        prod0;
    logic [14:0]        pc;
    logic [30:0]        dprod0;
    logic [DIV_W-1:0]   n_s0_n;
    logic [DEN_W-1:0]   n_s0_d;

    always_comb begin
        w0 = (i_kind == KIND_ADC) ? (i_channel ? r_adc_cal_b : r_adc_cal_a)
                                  : (i_channel ? r_dac_cal_b : r_dac_cal_a);
        den0 = (w0[63:40] == 24'd0) ? 24'd1 : w0[63:40];
        // offset then clamp to ADC full scale
        corr = $signed({2'b00, i_adc_code}) + 18'(signed'(w0[15:0]));
        if (corr < 18'sd0)
            x0 = 16'd0;
        else if (corr > $signed({2'b00, AMAX}))
            x0 = AMAX;
        else
            x0 = corr[15:0];
        prod0 = 40'(x0) * 40'(w0[39:16]);
        // pitch clamped to range
        if (i_target_pitch < 16'sd0)
            pc = 15'd0;
        else if ({1'b0, i_target_pitch[14:0]} > {1'b0, max_pitch} || i_target_pitch[15])
            pc = max_pitch;
        else
            pc = i_target_pitch[14:0];
        dprod0 = 31'(pc) * 31'(DMAX) + 31'(max_pitch >> 1);
        if (i_kind == KIND_ADC) begin
            n_s0_n = 41'(prod0) + 41'(den0 >> 1);
            n_s0_d = den0;
        end else if (max_pitch == 15'd0) begin
            n_s0_n = '0;
            n_s0_d = 24'd1;
        end else begin
            n_s0_n = 41'(dprod0);
            n_s0_d = 24'(max_pitch);
        end
    end

    t_ctl             r_s0_ctl;
    logic [DIV_W-1:0] r_s0_n;
    logic [DEN_W-1:0] r_s0_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
        end else begin
            r_s0_ctl.valid <= start;
        end
        r_s0_ctl.side <= {i_kind, i_channel};
        r_s0_n        <= n_s0_n;
        r_s0_d        <= n_s0_d;
    end

    // ---------------- first divider chain ----------------
    t_ctl             c1_ctl [0:DIV_W];
    logic [DIV_W-1:0] c1_n   [0:DIV_W];
    logic [DEN_W-1:0] c1_d   [0:DIV_W];
    logic [DEN_W-1:0] c1_r   [0:DIV_W];

    assign c1_ctl[0] = r_s0_ctl;
    assign c1_n[0]   = r_s0_n;
    assign c1_d[0]   = r_s0_d;
    assign c1_r[0]   = '0;

    for (genvar g = 0; g < DIV_W; g++) begin : g_c1
        cvpc_div_cell #(.DW(DIV_W), .RW(DEN_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (c1_ctl[g]),
            .i_n    (c1_n[g]),
            .i_d    (c1_d[g]),
            .i_r    (c1_r[g]),
            .o_ctl  (c1_ctl[g+1]),
            .o_n    (c1_n[g+1]),
            .o_d    (c1_d[g+1]),
            .o_r    (c1_r[g+1])
        );
    end

    // ---------------- middle stage: second dividend ----------------
    logic [63:0]      w1;
    logic [23:0]      den1;
    logic [DIV_W-1:0] q1;
    logic [15:0]      cal1;
    logic [15:0]      raw1;
    logic [30:0]      aprod1;
    logic [39:0]      gprod1;
    logic [DIV_W-1:0] n_s1_n;
    logic [DEN_W-1:0] n_s1_d;

    always_comb begin
        q1   = c1_n[DIV_W];
        w1   = c1_ctl[DIV_W].side[0] ? r_dac_cal_b : r_dac_cal_a;
        den1 = (w1[63:40] == 24'd0) ? 24'd1 : w1[63:40];
        cal1 = (q1 > DIV_W'(AMAX)) ? AMAX : q1[15:0];
        raw1 = (q1 > DIV_W'(DMAX)) ? DMAX : q1[15:0];
        aprod1 = 31'(cal1) * 31'(max_pitch) + 31'(AMAX >> 1);
        gprod1 = 40'(raw1) * 40'(w1[39:16]);
        if (c1_ctl[DIV_W].side[1] == KIND_ADC) begin
            n_s1_n = 41'(aprod1);
            n_s1_d = 24'(AMAX);
        end else begin
            n_s1_n = 41'(gprod1) + 41'(den1 >> 1);
            n_s1_d = den1;
        end
    end

    t_ctl             r_s1_ctl;
    logic [DIV_W-1:0] r_s1_n;
    logic [DEN_W-1:0] r_s1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else begin
            r_s1_ctl.valid <= c1_ctl[DIV_W].valid;
        end
        r_s1_ctl.side <= c1_ctl[DIV_W].side;
        r_s1_n        <= n_s1_n;
        r_s1_d        <= n_s1_d;
    end

    // ---------------- second divider chain ----------------
    t_ctl             c2_ctl [0:DIV_W];
    logic [DIV_W-1:0] c2_n   [0:DIV_W];
    logic [DEN_W-1:0] c2_d   [0:DIV_W];
    logic [DEN_W-1:0] c2_r   [0:DIV_W];

    assign c2_ctl[0] = r_s1_ctl;
    assign c2_n[0]   = r_s1_n;
    assign c2_d[0]   = r_s1_d;
    assign c2_r[0]   = '0;

    for (genvar g = 0; g < DIV_W; g++) begin : g_c2
        cvpc_div_cell #(.DW(DIV_W), .RW(DEN_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (c2_ctl[g]),
            .i_n    (c2_n[g]),
            .i_d    (c2_d[g]),
            .i_r    (c2_r[g]),
            .o_ctl  (c2_ctl[g+1]),
            .o_n    (c2_n[g+1]),
            .o_d    (c2_d[g+1]),
            .o_r    (c2_r[g+1])
        );
    end

    // output stage: DAC offset and clamp; ADC results pass through
    logic [63:0]        w2;
    logic [DIV_W-1:0]   q2;
    logic signed [42:0] v2;
    logic [15:0]        n_result;

    always_comb begin
        q2 = c2_n[DIV_W];
        w2 = c2_ctl[DIV_W].side[0] ? r_dac_cal_b : r_dac_cal_a;
        v2 = $signed({2'b00, q2}) + 43'(signed'(w2[15:0]));
        if (c2_ctl[DIV_W].side[1] == KIND_ADC)
            n_result = q2[15:0];
        else if (v2 < 43'sd0)
            n_result = 16'd0;
        else if (v2 > $signed(43'(DMAX)))
            n_result = DMAX;
        else
            n_result = v2[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= c2_ctl[DIV_W].valid;
        end
        o_result_value <= n_result;
    end

endmodule

// ===== src/cvpc_div_cell.sv =====
module cvpc_div_cell
    import cvpc_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int RW = DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_n,
    input  logic [RW-1:0] i_d,
    input  logic [RW-1:0] i_r,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_n,
    output logic [RW-1:0] o_d,
    output logic [RW-1:0] o_r
);

    logic [RW:0]   r2;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] n_r;
    logic [DW-1:0] n_n;

    // one restoring step: shift in the top dividend bit, trial subtract
    always_comb begin
        r2   = {i_r, i_n[DW-1]};
        diff = r2 - {1'b0, i_d};
        ge   = (r2 >= {1'b0, i_d});
        n_r  = ge ? diff[RW-1:0] : r2[RW-1:0];
        n_n  = {i_n[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.side <= i_ctl.side;
        o_n        <= n_n;
        o_d        <= i_d;
        o_r        <= n_r;
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import cvpc_pkg::*;

    localparam longint ADC_FS = (1 << ADC_BITS_DEF) - 1;
    localparam longint DAC_FS = (1 << DAC_BITS_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 180;

    typedef struct {
        logic        kind;
        logic        chan;
        logic [15:0] code;
        logic [15:0] pitch;
        logic        known;
        logic [15:0] value;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_kind = 1'b0;
    logic               i_channel = 1'b0;
    logic [15:0]        i_adc_code = '0;
    logic signed [15:0] i_target_pitch = '0;
    logic               o_valid;
    logic [15:0]        o_result_value;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;

    // local copy of the calibration registers
    logic [63:0] cal_words [4];
    logic [6:0]  range_semis;

    logic [15:0] pending_values [$];
    logic        row_known;
    logic [15:0] row_value;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          no_gaps;

    t_row rows [$];

    calibrated_cv_pitch_converter_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_adc_code     (i_adc_code),
        .i_target_pitch (i_target_pitch),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint cal_offset(logic [63:0] w);
        return longint'($signed(w[15:0]));
    endfunction

    // rounded gain: (x * num + den / 2) / den, zero denominator taken as one
    function automatic longint cal_gain(longint x, logic [63:0] w);
        longint num;
        longint den;
        num = longint'(w[39:16]);
        den = (w[63:40] == 0) ? 1 : longint'(w[63:40]);
        return (x * num + den / 2) / den;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [15:0] convert_cv(logic kind, logic chan,
                                               logic [15:0] code, logic [15:0] pitch);
        logic [63:0] w;
        longint      span;
        longint      v;
        longint      p;
        longint      raw;
        span = longint'(range_semis) * 256;
        if (kind == KIND_ADC) begin
            w = cal_words[chan ? REG_ADC_CAL_B : REG_ADC_CAL_A];
            v = clamp(longint'(code) + cal_offset(w), 0, ADC_FS);
            v = clamp(cal_gain(v, w), 0, ADC_FS);
            v = (v * span + ADC_FS / 2) / ADC_FS;
        end else begin
            w = cal_words[chan ? REG_DAC_CAL_B : REG_DAC_CAL_A];
            p = longint'($signed(pitch));
            raw = 0;
            // zero range: raw DAC code is taken as zero
            if (span > 0) begin
                p = clamp(p, 0, span);
                raw = (p * DAC_FS + span / 2) / span;
            end
            raw = clamp(raw, 0, DAC_FS);
            v = clamp(cal_gain(raw, w) + cal_offset(w), 0, DAC_FS);
        end
        return v[15:0];
    endfunction

    // output check first, then capture of the item taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_words[0] <= CAL_RESET;
            cal_words[1] <= CAL_RESET;
            cal_words[2] <= CAL_RESET;
            cal_words[3] <= CAL_RESET;
            range_semis  <= RANGE_RESET;
        end else begin
            if (o_valid) begin
                if (pending_values.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value %0d", o_result_value);
                end else if (pending_values[0] !== o_result_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_value: expected %0d, got %0d",
                                 pending_values[0], o_result_value);
                    void'(pending_values.pop_front());
                end else begin
                    void'(pending_values.pop_front());
                end
            end
            if (start && !busy) begin
                if (row_known)
                    pending_values.push_back(row_value);
                else
                    pending_values.push_back(convert_cv(i_kind, i_channel,
                                                        i_adc_code, i_target_pitch));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ADC_CAL_A, REG_ADC_CAL_B,
                    REG_DAC_CAL_A, REG_DAC_CAL_B: cal_words[i_cfg_index] <= i_cfg_data;
                    REG_RANGE: range_semis <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic kind, logic chan, logic [15:0] code,
                             logic [15:0] pitch, logic known, logic [15:0] value);
        @(negedge i_clk);
        start          <= 1'b1;
        i_kind         <= kind;
        i_channel      <= chan;
        i_adc_code     <= code;
        i_target_pitch <= pitch;
        row_known      <= known;
        row_value      <= value;
        while (busy) @(negedge i_clk);
    endtask

    task automatic idle_for(int n);
        repeat (n) begin
            @(negedge i_clk);
            start     <= 1'b0;
            row_known <= 1'b0;
        end
    endtask

    task automatic idle_random();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65)
            return;
        else if (r < 93)
            idle_for($urandom_range(3, 1));
        else
            idle_for($urandom_range(60, 10));
    endtask

    task automatic drain_results();
        idle_for(1);
        while (pending_values.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_cal(int phase);
        logic [15:0] off;
        logic [23:0] num;
        logic [23:0] den;
        case ($urandom_range(3))
            0: off = 16'h8000;
            1: off = 16'h7FFF;
            2: off = 16'($signed($urandom_range(400)) - 200);
            default: off = 16'($urandom);
        endcase
        den = 24'($urandom_range(4096, 1));
        case ($urandom_range(5))
            0: num = '0;
            1: num = 24'hFFFFFF;
            2: num = den + 24'($urandom_range(64)) - 24'd32;
            3: num = 24'($urandom);
            default: num = den;
        endcase
        // extreme denominators in random phases 1 and 2
        if (phase == 1) den = '0;
        if (phase == 2) den = 24'hFFFFFF;
        if (phase == 2 && $urandom_range(1)) num = 24'hFFFFFF;
        return {den, num, off};
    endfunction

    function automatic logic [15:0] random_code();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(4200));
            2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(4095, 3900));
        endcase
    endfunction

    function automatic logic [15:0] random_pitch();
        longint span;
        span = longint'(range_semis) * 256;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(32767));
            2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(int'(span) + 300));
        endcase
    endfunction

    initial begin
        int       n;
        int       ph;
        logic [6:0] rng;

        // directed items at reset calibration (offset 0, gain 1, range 60)
        rows.push_back('{KIND_ADC, 1'b0, 16'd0,     16'd0,      1'b1, 16'd0});
        rows.push_back('{KIND_ADC, 1'b0, 16'd4095,  16'd0,      1'b1, 16'd15360});
        rows.push_back('{KIND_ADC, 1'b1, 16'hFFFF,  16'd0,      1'b1, 16'd15360});
        rows.push_back('{KIND_ADC, 1'b1, 16'd2048,  16'hFFFF,   1'b0, 16'd0});
        rows.push_back('{KIND_ADC, 1'b0, 16'd1,     16'h8000,   1'b0, 16'd0});
        rows.push_back('{KIND_ADC, 1'b1, 16'd4096,  16'd0,      1'b1, 16'd15360});
        rows.push_back('{KIND_DAC, 1'b0, 16'hFFFF,  16'h8000,   1'b1, 16'd0});
        rows.push_back('{KIND_DAC, 1'b1, 16'd0,     16'h7FFF,   1'b1, 16'd4095});
        rows.push_back('{KIND_DAC, 1'b0, 16'd0,     16'd0,      1'b1, 16'd0});
        rows.push_back('{KIND_DAC, 1'b1, 16'd0,     16'd15360,  1'b1, 16'd4095});
        rows.push_back('{KIND_DAC, 1'b0, 16'd0,     16'd7680,   1'b0, 16'd0});
        rows.push_back('{KIND_DAC, 1'b1, 16'd0,     16'hFFFF,   1'b1, 16'd0});
        rows.push_back('{KIND_DAC, 1'b0, 16'd0,     16'd15361,  1'b1, 16'd4095});

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_item(rows[i].kind, rows[i].chan, rows[i].code, rows[i].pitch,
                      rows[i].known, rows[i].value);
        end
        drain_results();

        // zero range: pitch 0 on the ADC side, raw code 0 on the DAC side
        write_reg(REG_RANGE, 64'd0);
        send_item(KIND_ADC, 1'b0, 16'd4095, 16'd0, 1'b1, 16'd0);
        send_item(KIND_DAC, 1'b1, 16'd0, 16'h7FFF, 1'b1, 16'd0);
        drain_results();
        write_reg(REG_DAC_CAL_A, {24'd1, 24'd1, 16'd100});
        send_item(KIND_DAC, 1'b0, 16'd0, 16'h4000, 1'b1, 16'd100);
        drain_results();

        for (ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < 4; r++) write_reg(3'(r), random_cal(ph));
            case (ph)
                0: rng = 7'd127;
                1: rng = 7'd1;
                2: rng = 7'd0;
                3: rng = {1'b1, 6'($urandom)};   // upper data bits ignored
                default: rng = 7'($urandom_range(127, 1));
            endcase
            write_reg(REG_RANGE, ph == 3 ? {57'h1, rng} : {57'd0, rng});
            no_gaps = (ph == 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item($urandom_range(1), $urandom_range(1), random_code(),
                          random_pitch(), 1'b0, 16'd0);
                // hold off mid-phase until the pipeline is empty
                if (ph == 5 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                else
                    idle_random();
            end
            drain_results();
        end

        idle_for(100);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cvpc_pkg.sv
src/cvpc_div_cell.sv
src/calibrated_cv_pitch_converter_unit.sv
bench/tb_top.sv
